>>> sv/dfp_pkg.sv
// Shared types and constants of the delimited decimal field parser.
`default_nettype none

package dfp_pkg;

	// Character codes with a fixed meaning.
	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO_DIGIT = 8'd48;
	localparam logic [7:0] CHAR_NUL = 8'd0;

	// Reset values of the configuration registers.
	localparam logic [7:0] DELIM_RESET = 8'd44;
	localparam logic [7:0] END_RESET = 8'd10;

	// Register indexes on the configuration port.
	localparam logic REG_DELIM = 1'b0;
	localparam logic REG_END = 1'b1;

	// Class that the front end gives to each character.
	typedef enum logic [1:0] {
		KIND_END,
		KIND_NUL,
		KIND_DELIM,
		KIND_CHAR
	} dfp_kind_t;

	// A classified character on its way to the back end.
	typedef struct packed {
		dfp_kind_t  kind;
		logic [7:0] ch;
	} dfp_item_t;

	// Configuration register contents.
	typedef struct packed {
		logic [7:0] delim;
		logic [7:0] endc;
	} dfp_cfg_t;

	// One emitted field.
	typedef struct packed {
		logic signed [31:0] value;
		logic [7:0]         index;
		logic               last;
		logic               overflow;
	} dfp_result_t;

endpackage

`default_nettype wire

>>> sv/dfp_fifo.sv
// Small register-based first-in first-out queue.
`default_nettype none

module dfp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

>>> sv/dfp_front.sv
// Front end: accepts characters, classifies them and queues them for the back end.
`default_nettype none

module dfp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [7:0]          rx_char,
	output logic                full,
	input  dfp_pkg::dfp_cfg_t   cfg,
	output logic                item_valid,
	input  logic                item_pop,
	output dfp_pkg::dfp_item_t  item
);

	import dfp_pkg::*;

	dfp_item_t item_in;
	logic      item_empty;

	// The end character wins over everything, a zero byte over the delimiter.
	always_comb begin
		item_in.ch = rx_char;
		priority if (rx_char == cfg.endc) begin
			item_in.kind = KIND_END;
		end else if (rx_char == CHAR_NUL) begin
			item_in.kind = KIND_NUL;
		end else if (rx_char == cfg.delim) begin
			item_in.kind = KIND_DELIM;
		end else begin
			item_in.kind = KIND_CHAR;
		end
	end

	// Queue between front and back end.
	dfp_fifo #(
		.WIDTH($bits(dfp_item_t)),
		.DEPTH(2)
	) u_item_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (item_in),
		.full   (full),
		.pop    (item_pop),
		.rdata  (item),
		.empty  (item_empty)
	);

	assign item_valid = !item_empty;

endmodule

`default_nettype wire

>>> sv/dfp_back.sv
// Back end: accumulates field values and queues the emitted fields.
`default_nettype none

module dfp_back #(
	parameter int MAX_FIELDS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  dfp_pkg::dfp_item_t   item,
	output logic                 item_pop,
	input  logic                 pop,
	output logic                 empty,
	output dfp_pkg::dfp_result_t result
);

	import dfp_pkg::*;

	localparam int INDEX_LIMIT = (MAX_FIELDS - 1 > 255) ? 255 : MAX_FIELDS - 1;

	logic [31:0] acc_q;
	logic        neg_q;
	logic        start_q;
	logic [7:0]  index_q;
	logic        ovf_q;
	logic        stopped_q;

	logic        res_full;
	logic        take;
	logic        emit;
	logic        emit_last;
	logic [31:0] acc_next;
	dfp_result_t res_in;

	// An item is taken whenever the result queue has room.
	assign take     = item_valid && !res_full;
	assign item_pop = take;

	// Fields are emitted by the end character, and by a delimiter on a live line.
	always_comb begin
		emit      = 1'b0;
		emit_last = 1'b0;
		if (take) begin
			if (item.kind == KIND_END) begin
				emit      = 1'b1;
				emit_last = 1'b1;
			end else if (!stopped_q && item.kind == KIND_DELIM) begin
				emit = 1'b1;
			end
		end
	end

	// Value times ten plus the character code less the code of zero, wrapping.
	assign acc_next = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0}
		+ {24'd0, item.ch} - {24'd0, CHAR_ZERO_DIGIT};

	assign res_in.value    = neg_q ? 32'(-acc_q) : acc_q;
	assign res_in.index    = index_q;
	assign res_in.last     = emit_last;
	assign res_in.overflow = ovf_q;

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			neg_q     <= 1'b0;
			start_q   <= 1'b1;
			index_q   <= '0;
			ovf_q     <= 1'b0;
			stopped_q <= 1'b0;
		end else if (take) begin
			if (item.kind == KIND_END) begin
				acc_q     <= '0;
				neg_q     <= 1'b0;
				start_q   <= 1'b1;
				index_q   <= '0;
				ovf_q     <= 1'b0;
				stopped_q <= 1'b0;
			end else if (!stopped_q) begin
				unique case (item.kind)
					KIND_NUL: begin
						stopped_q <= 1'b1;
					end
					KIND_DELIM: begin
						acc_q   <= '0;
						neg_q   <= 1'b0;
						start_q <= 1'b1;
						if (index_q >= 8'(INDEX_LIMIT)) begin
							ovf_q <= 1'b1;
						end else begin
							index_q <= index_q + 1'b1;
						end
					end
					KIND_CHAR: begin
						start_q <= 1'b0;
						if (start_q && item.ch == CHAR_MINUS) begin
							neg_q <= 1'b1;
						end else begin
							acc_q <= acc_next;
						end
					end
					default: begin
						stopped_q <= stopped_q;
					end
				endcase
			end
		end
	end

	// Output queue decouples the result side.
	dfp_fifo #(
		.WIDTH($bits(dfp_result_t)),
		.DEPTH(2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (emit),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

`default_nettype wire

>>> sv/delimited_decimal_field_parser_unit.sv
// Top level of the delimited decimal field parser with its configuration registers.
//
//  Channel     Direction  Transfer when
//  ----------  ---------  ------------------------------------------
//  rx_char     in         push && !full
//  field_*     out        pop && !empty
//  config      in         psel && penable && pwrite (pready tied high)
//
// One character per cycle is sustained when neither queue is backed up; a
// field is written into the result queue when the delimiter or end character
// that closes it is taken from the character queue.
// Each side has a two-entry queue, so push and pop stall independently.
// Reset clears the parser state and sets delimiter 44 and end character 10.
`default_nettype none

module delimited_decimal_field_parser_unit #(
	parameter int MAX_FIELDS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_char,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] field_value,
	output logic [7:0]         field_index,
	output logic               last_field,
	output logic               too_many_fields,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	import dfp_pkg::*;

	dfp_cfg_t    cfg_q;
	dfp_item_t   item;
	logic        item_valid;
	logic        item_pop;
	dfp_result_t result;
	logic        cfg_wr;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delim <= DELIM_RESET;
			cfg_q.endc  <= END_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_DELIM: cfg_q.delim <= pwdata[7:0];
				REG_END:   cfg_q.endc  <= pwdata[7:0];
				default:   cfg_q       <= cfg_q;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[2])
			REG_DELIM: prdata = {24'd0, cfg_q.delim};
			REG_END:   prdata = {24'd0, cfg_q.endc};
			default:   prdata = '0;
		endcase
	end

	dfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.rx_char    (rx_char),
		.full       (full),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.item       (item)
	);

	dfp_back #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

	assign field_value     = result.value;
	assign field_index     = result.index;
	assign last_field      = result.last;
	assign too_many_fields = result.overflow;

endmodule

`default_nettype wire

>>> sv/dfp_checker.sv
// Port-level checks of the field parser and their binding to the top level.
`default_nettype none

module dfp_checker #(
	parameter int MAX_FIELDS = 256
) (
	input wire               clk,
	input wire               arst_n,
	input wire               empty,
	input wire               pop,
	input wire signed [31:0] field_value,
	input wire [7:0]         field_index,
	input wire               last_field,
	input wire               too_many_fields,
	input wire               psel,
	input wire               penable,
	input wire               pwrite,
	input wire [2:0]         paddr,
	input wire [31:0]        pwdata,
	input wire [31:0]        prdata
);

	localparam int INDEX_LIMIT = (MAX_FIELDS - 1 > 255) ? 255 : MAX_FIELDS - 1;

	// A waiting field holds until it is transferred.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(field_value) && $stable(field_index)
			&& $stable(last_field) && $stable(too_many_fields))
		else $error("waiting field changed before transfer");

	// Overflow is only flagged once the index has saturated.
	a_ovf_index: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && too_many_fields |-> field_index == 8'(INDEX_LIMIT))
		else $error("overflow flagged below the index limit");

	// The index never exceeds its limit.
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> field_index <= 8'(INDEX_LIMIT))
		else $error("field index beyond its limit");

	// A written register reads back its low byte.
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite ##1 paddr[2] == $past(paddr[2])
			|-> prdata == {24'd0, $past(pwdata[7:0])})
		else $error("register read-back mismatch");

endmodule

bind delimited_decimal_field_parser_unit dfp_checker #(
	.MAX_FIELDS(MAX_FIELDS)
) u_dfp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.empty           (empty),
	.pop             (pop),
	.field_value     (field_value),
	.field_index     (field_index),
	.last_field      (last_field),
	.too_many_fields (too_many_fields),
	.psel            (psel),
	.penable         (penable),
	.pwrite          (pwrite),
	.paddr           (paddr),
	.pwdata          (pwdata),
	.prdata          (prdata)
);

`default_nettype wire
